FILE: rtl/jccs_pkg.sv
// ----------------------------------------------------------------------------
// jccs_pkg
// Shared types, character codes and controller/datapath interface structs
// for the JSON comment and trailing-comma stripper.
// ----------------------------------------------------------------------------
package jccs_pkg;

    localparam int WS_DEPTH = 32;
    localparam int CNT_W    = $clog2(WS_DEPTH + 1);
    localparam int IDX_W    = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;

    localparam logic [15:0] CH_QUOTE  = 16'h0022;
    localparam logic [15:0] CH_BSLASH = 16'h005C;
    localparam logic [15:0] CH_SLASH  = 16'h002F;
    localparam logic [15:0] CH_STAR   = 16'h002A;
    localparam logic [15:0] CH_COMMA  = 16'h002C;
    localparam logic [15:0] CH_RBRACE = 16'h007D;
    localparam logic [15:0] CH_RBRACK = 16'h005D;
    localparam logic [15:0] CH_SPACE  = 16'h0020;
    localparam logic [15:0] CH_TAB    = 16'h0009;
    localparam logic [15:0] CH_CR     = 16'h000D;
    localparam logic [15:0] CH_LF     = 16'h000A;

    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_STRING = 3'd1;
    localparam logic [2:0] MODE_ESCAPE = 3'd2;
    localparam logic [2:0] MODE_SLASH  = 3'd3;
    localparam logic [2:0] MODE_LINE   = 3'd4;
    localparam logic [2:0] MODE_BLOCK  = 3'd5;
    localparam logic [2:0] MODE_STAR   = 3'd6;
    localparam logic [2:0] MODE_COMMA  = 3'd7;

    localparam logic [1:0] SEL_X    = 2'd0;
    localparam logic [1:0] SEL_WS   = 2'd1;
    localparam logic [1:0] SEL_Y    = 2'd2;
    localparam logic [1:0] SEL_BARE = 2'd3;

    localparam logic [1:0] WS_SPACE = 2'd0;
    localparam logic [1:0] WS_TAB   = 2'd1;
    localparam logic [1:0] WS_CR    = 2'd2;
    localparam logic [1:0] WS_LF    = 2'd3;

    typedef struct packed {
        logic [15:0] in_char;
        logic        is_last;
    } t_in;

    typedef struct packed {
        logic [15:0] out_char;
        logic        char_valid;
        logic        last_of_run;
        logic        end_of_text;
    } t_out;

    typedef struct packed {
        logic       live;
        logic       accept;
        logic       emit;
        logic [1:0] sel;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic has_x;
        logic n_zero;
        logic has_y;
        logic bare;
        logic ws_more;
    } t_dp_status;

    function automatic logic [15:0] ws_char(input logic [1:0] code);
        logic [15:0] ch;
        case (code)
            WS_SPACE: ch = CH_SPACE;
            WS_TAB:   ch = CH_TAB;
            WS_CR:    ch = CH_CR;
            default:  ch = CH_LF;
        endcase
        return ch;
    endfunction

endpackage

FILE: rtl/jccs_dp.sv
// ----------------------------------------------------------------------------
// jccs_dp
// Datapath: scan mode, whitespace hold buffer, per-beat emission plan and
// the output register.
// ----------------------------------------------------------------------------
module jccs_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  jccs_pkg::t_in       i_in_data,
    input  jccs_pkg::t_dp_cmd   i_cmd,
    input  logic                i_out_stall,
    output jccs_pkg::t_dp_status o_status,
    output logic                o_out_valid,
    output jccs_pkg::t_out      o_out_data
);
    import jccs_pkg::*;

    logic [2:0]       r_mode;
    logic [CNT_W-1:0] r_cnt;
    logic [1:0]       r_ws [WS_DEPTH];
    logic             r_has_x;
    logic             r_x_comma;
    logic [CNT_W-1:0] r_n;
    logic             r_has_y;
    logic [15:0]      r_y;
    logic             r_last;
    logic [CNT_W-1:0] r_idx;
    logic             r_out_valid;
    t_out             r_out;

    logic [15:0]      c;
    logic             last;
    logic             is_ws;
    logic [1:0]       code;
    logic             nu_emit;
    logic [2:0]       nu_mode;

    logic             d_has_x;
    logic             d_x_comma;
    logic [CNT_W-1:0] d_n;
    logic             d_has_y;
    logic [15:0]      d_y;
    logic [2:0]       d_mode;
    logic [CNT_W-1:0] d_cnt;
    logic             d_wr;
    logic             d_bare;

    logic             p_has_x;
    logic             p_x_comma;
    logic [CNT_W-1:0] p_n;
    logic             p_has_y;
    logic [15:0]      p_y;
    logic             p_last;
    logic [CNT_W-1:0] cur_idx;
    logic             ws_more;
    logic             n_zero;
    t_out             n_out;
    logic             fin;

    assign c    = i_in_data.in_char;
    assign last = i_in_data.is_last;

    always_comb begin
        is_ws = 1'b1;
        code  = WS_SPACE;
        case (c)
            CH_SPACE: code = WS_SPACE;
            CH_TAB:   code = WS_TAB;
            CH_CR:    code = WS_CR;
            CH_LF:    code = WS_LF;
            default:  is_ws = 1'b0;
        endcase
    end

    always_comb begin
        nu_emit = !(c == CH_SLASH || c == CH_COMMA);
        if (c == CH_QUOTE) begin
            nu_mode = MODE_STRING;
        end else if (c == CH_SLASH) begin
            nu_mode = MODE_SLASH;
        end else if (c == CH_COMMA) begin
            nu_mode = MODE_COMMA;
        end else begin
            nu_mode = MODE_NORMAL;
        end
    end

    always_comb begin
        d_has_x   = 1'b0;
        d_x_comma = 1'b0;
        d_n       = '0;
        d_has_y   = 1'b0;
        d_y       = c;
        d_mode    = r_mode;
        d_cnt     = r_cnt;
        d_wr      = 1'b0;
        case (r_mode)
            MODE_STRING: begin
                d_has_y = 1'b1;
                if (c == CH_BSLASH) begin
                    d_mode = MODE_ESCAPE;
                end else if (c == CH_QUOTE) begin
                    d_mode = MODE_NORMAL;
                end
            end
            MODE_ESCAPE: begin
                d_has_y = 1'b1;
                d_mode  = MODE_STRING;
            end
            MODE_SLASH: begin
                if (c == CH_SLASH) begin
                    d_mode = MODE_LINE;
                end else if (c == CH_STAR) begin
                    d_mode = MODE_BLOCK;
                end else begin
                    d_has_x = 1'b1;
                    d_has_y = nu_emit;
                    d_mode  = nu_mode;
                    if (c == CH_COMMA) begin
                        d_cnt = '0;
                    end
                end
            end
            MODE_LINE: begin
                if (c == CH_LF) begin
                    d_has_y = 1'b1;
                    d_mode  = MODE_NORMAL;
                end
            end
            MODE_BLOCK: begin
                if (c == CH_STAR) begin
                    d_mode = MODE_STAR;
                end
            end
            MODE_STAR: begin
                if (c == CH_SLASH) begin
                    d_mode = MODE_NORMAL;
                end else if (c != CH_STAR) begin
                    d_mode = MODE_BLOCK;
                end
            end
            MODE_COMMA: begin
                if (is_ws) begin
                    if (r_cnt < CNT_W'(WS_DEPTH)) begin
                        d_wr  = 1'b1;
                        d_cnt = r_cnt + CNT_W'(1);
                    end else begin
                        d_has_x   = 1'b1;
                        d_x_comma = 1'b1;
                        d_n       = r_cnt;
                        d_has_y   = 1'b1;
                        d_mode    = MODE_NORMAL;
                        d_cnt     = '0;
                    end
                end else if (c == CH_RBRACE || c == CH_RBRACK) begin
                    d_n     = r_cnt;
                    d_has_y = 1'b1;
                    d_mode  = MODE_NORMAL;
                    d_cnt   = '0;
                end else begin
                    d_has_x   = 1'b1;
                    d_x_comma = 1'b1;
                    d_n       = r_cnt;
                    d_has_y   = nu_emit;
                    d_mode    = nu_mode;
                    d_cnt     = '0;
                end
            end
            default: begin
                d_has_y = nu_emit;
                d_mode  = nu_mode;
                if (c == CH_COMMA) begin
                    d_cnt = '0;
                end
            end
        endcase

        // end of text: release a held slash or comma, then back to reset state
        if (last) begin
            if (d_mode == MODE_SLASH) begin
                d_has_y = 1'b1;
                d_y     = CH_SLASH;
            end else if (d_mode == MODE_COMMA) begin
                if (d_wr) begin
                    d_has_x   = 1'b1;
                    d_x_comma = 1'b1;
                    d_n       = d_cnt;
                end else begin
                    d_has_y = 1'b1;
                    d_y     = CH_COMMA;
                end
            end
            d_mode = MODE_NORMAL;
            d_cnt  = '0;
        end
        d_bare = last && !d_has_x && (d_n == '0) && !d_has_y;
    end

    assign p_has_x   = i_cmd.live ? d_has_x   : r_has_x;
    assign p_x_comma = i_cmd.live ? d_x_comma : r_x_comma;
    assign p_n       = i_cmd.live ? d_n       : r_n;
    assign p_has_y   = i_cmd.live ? d_has_y   : r_has_y;
    assign p_y       = i_cmd.live ? d_y       : r_y;
    assign p_last    = i_cmd.live ? last      : r_last;
    assign cur_idx   = i_cmd.live ? '0        : r_idx;

    assign n_zero  = (p_n == '0);
    assign ws_more = ({1'b0, cur_idx} + (CNT_W + 1)'(1)) < {1'b0, p_n};

    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_status.has_x    = p_has_x;
    assign o_status.n_zero   = n_zero;
    assign o_status.has_y    = p_has_y;
    assign o_status.bare     = i_cmd.live && d_bare;
    assign o_status.ws_more  = ws_more;

    always_comb begin
        n_out = '0;
        fin   = 1'b1;
        case (i_cmd.sel)
            SEL_X: begin
                n_out.out_char   = p_x_comma ? CH_COMMA : CH_SLASH;
                n_out.char_valid = 1'b1;
                fin              = n_zero && !p_has_y;
            end
            SEL_WS: begin
                n_out.out_char   = ws_char(r_ws[cur_idx[IDX_W-1:0]]);
                n_out.char_valid = 1'b1;
                fin              = !ws_more && !p_has_y;
            end
            SEL_Y: begin
                n_out.out_char   = p_y;
                n_out.char_valid = 1'b1;
            end
            default: begin
                n_out.out_char   = '0;
                n_out.char_valid = 1'b0;
            end
        endcase
        n_out.last_of_run = fin;
        n_out.end_of_text = fin && p_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_NORMAL;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_mode <= d_mode;
                r_cnt  <= d_cnt;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && d_wr) begin
            r_ws[r_cnt[IDX_W-1:0]] <= code;
        end
        if (i_cmd.accept) begin
            r_has_x   <= d_has_x;
            r_x_comma <= d_x_comma;
            r_n       <= d_n;
            r_has_y   <= d_has_y;
            r_y       <= d_y;
            r_last    <= last;
            r_idx     <= d_has_x ? '0 : CNT_W'(1);
        end else if (i_cmd.emit && i_cmd.sel == SEL_WS) begin
            r_idx <= r_idx + CNT_W'(1);
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/jccs_ctrl.sv
// ----------------------------------------------------------------------------
// jccs_ctrl
// Controller: takes an item when the output register is free and walks its
// emission plan (held char, whitespace flush, final char) one beat a cycle while the output is free.
// ----------------------------------------------------------------------------
module jccs_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  jccs_pkg::t_dp_status i_status,
    output jccs_pkg::t_dp_cmd    o_cmd,
    output logic                 o_in_stall
);
    import jccs_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WS   = 2'd1;
    localparam logic [1:0] S_Y    = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    t_dp_cmd    cmd;
    logic       after_ws;

    assign after_ws = i_status.has_y;

    always_comb begin
        n_state    = r_state;
        cmd        = '0;
        cmd.sel    = SEL_BARE;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                cmd.live   = 1'b1;
                o_in_stall = !i_status.out_free;
                if (i_in_valid && i_status.out_free) begin
                    cmd.accept = 1'b1;
                    if (i_status.has_x) begin
                        cmd.emit = 1'b1;
                        cmd.sel  = SEL_X;
                        if (!i_status.n_zero) begin
                            n_state = S_WS;
                        end else if (i_status.has_y) begin
                            n_state = S_Y;
                        end
                    end else if (!i_status.n_zero) begin
                        cmd.emit = 1'b1;
                        cmd.sel  = SEL_WS;
                        if (i_status.ws_more) begin
                            n_state = S_WS;
                        end else if (after_ws) begin
                            n_state = S_Y;
                        end
                    end else if (i_status.has_y) begin
                        cmd.emit = 1'b1;
                        cmd.sel  = SEL_Y;
                    end else if (i_status.bare) begin
                        cmd.emit = 1'b1;
                        cmd.sel  = SEL_BARE;
                    end
                end
            end
            S_WS: begin
                cmd.sel = SEL_WS;
                if (i_status.out_free) begin
                    cmd.emit = 1'b1;
                    if (!i_status.ws_more) begin
                        n_state = after_ws ? S_Y : S_IDLE;
                    end
                end
            end
            S_Y: begin
                cmd.sel = SEL_Y;
                if (i_status.out_free) begin
                    cmd.emit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = cmd;

endmodule

FILE: rtl/json_comment_comma_stripper.sv
// ----------------------------------------------------------------------------
// json_comment_comma_stripper
// Filters a UTF-16 JSON text stream: drops comments and trailing commas
// outside strings, tracking escapes inside them.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_stall   i_in_data  (t_in)
//  out      output     o_out_valid / i_out_stall o_out_data (t_out)
//
//  An item giving zero or one beat is taken without holding the input, back to back.
//  An item giving k > 1 beats (held slash or comma, whitespace flush of up to
//  32 units, final unit) holds the input until its last beat, one beat per cycle.
//  Output stall holds the output register and, through it, the input.
//  Synchronous active-low reset returns the scanner to normal text mode.
// ----------------------------------------------------------------------------
module json_comment_comma_stripper (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  jccs_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output jccs_pkg::t_out  o_out_data
);
    import jccs_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    jccs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    jccs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
